FILE: rtl/core/cpu8_pkg.sv
// Package with shared types, state codes and opcodes of the cpu8 core.
package cpu8_pkg;

  localparam int MEM_DEPTH = 65536;
  localparam int MEM_AW = $clog2(MEM_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_OPER1,
    ST_OPER2,
    ST_RD1,
    ST_RD2,
    ST_EXEC,
    ST_WR2,
    ST_DONE
  } state_t;

  // Memory address source selects.
  typedef enum logic [2:0] {
    AS_PC,
    AS_PC1,
    AS_PC2,
    AS_HL,
    AS_DE,
    AS_WORD,
    AS_SP,
    AS_SP1
  } addr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    addr_sel_t  addr_sel;
    logic       mem_we;
    logic [7:0] wdata;
    logic       use_load;
    logic       cap_op;
    logic       cap_b1;
    logic       cap_b2;
    logic       cap_m1;
    logic       exec;
    logic       clr_op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [7:0] op;
  } stat_t;

  localparam logic [7:0] OP_NOP  = 8'h00, OP_LXIB = 8'h01, OP_LXID = 8'h11;
  localparam logic [7:0] OP_LXIH = 8'h21, OP_LXIS = 8'h31, OP_DCRB = 8'h05;
  localparam logic [7:0] OP_DCRC = 8'h0d, OP_MVIB = 8'h06, OP_MVIC = 8'h0e;
  localparam logic [7:0] OP_MVIH = 8'h26, OP_MVIA = 8'h3e, OP_MVIM = 8'h36;
  localparam logic [7:0] OP_DADB = 8'h09, OP_DADD = 8'h19, OP_DADH = 8'h29;
  localparam logic [7:0] OP_RRC  = 8'h0f, OP_INXD = 8'h13, OP_INXH = 8'h23;
  localparam logic [7:0] OP_LDAX = 8'h1a, OP_STA  = 8'h32, OP_LDA  = 8'h3a;
  localparam logic [7:0] OP_MOVDM = 8'h56, OP_MOVEM = 8'h5e, OP_MOVHM = 8'h66;
  localparam logic [7:0] OP_MOVLA = 8'h6f, OP_MOVMA = 8'h77, OP_MOVAD = 8'h7a;
  localparam logic [7:0] OP_MOVAE = 8'h7b, OP_MOVAH = 8'h7c, OP_MOVAM = 8'h7e;
  localparam logic [7:0] OP_ANA  = 8'ha7, OP_XRA  = 8'haf, OP_ANI  = 8'he6;
  localparam logic [7:0] OP_ADI  = 8'hc6, OP_CPI  = 8'hfe, OP_JMP  = 8'hc3;
  localparam logic [7:0] OP_JNZ  = 8'hc2, OP_CALL = 8'hcd, OP_RET  = 8'hc9;
  localparam logic [7:0] OP_POPB = 8'hc1, OP_POPD = 8'hd1, OP_POPH = 8'he1;
  localparam logic [7:0] OP_PSHB = 8'hc5, OP_PSHD = 8'hd5, OP_PSHH = 8'he5;
  localparam logic [7:0] OP_PSHP = 8'hf5, OP_POPP = 8'hf1, OP_OUT  = 8'hd3;
  localparam logic [7:0] OP_XCHG = 8'heb, OP_EI   = 8'hfb;

  // Number of operand bytes that follow the opcode.
  function automatic logic [1:0] oper_len(input logic [7:0] op);
    case (op)
      OP_LXIB, OP_LXID, OP_LXIH, OP_LXIS, OP_STA, OP_LDA, OP_JMP, OP_JNZ,
      OP_CALL: oper_len = 2'd2;
      OP_MVIB, OP_MVIC, OP_MVIH, OP_MVIA, OP_MVIM, OP_ANI, OP_ADI, OP_CPI,
      OP_OUT: oper_len = 2'd1;
      default: oper_len = 2'd0;
    endcase
  endfunction

  function automatic logic even_par(input logic [7:0] v);
    even_par = ~^v;
  endfunction

endpackage

FILE: rtl/core/cpu8_ram.sv
// Generic single-port RAM with registered read.
module cpu8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/cpu8_dp.sv
// Datapath of the cpu8 core: register file, ALU, address mux and memory.
module cpu8_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  cpu8_pkg::cmd_t  cmd,
  input  logic [15:0]     load_address,
  input  logic [7:0]      load_byte,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_data,
  output cpu8_pkg::stat_t stat,
  output logic [15:0]     word,
  output logic [7:0]      a_val,
  output logic [7:0]      b1_val,
  output logic [15:0]     bc_val,
  output logic [15:0]     de_val,
  output logic [15:0]     hl_val,
  output logic [15:0]     pc_val,
  output logic [15:0]     sp_val,
  output logic [4:0]      f_val,
  output logic [7:0]      opcode_done,
  output logic            opcode_known,
  output logic [15:0]     pc_out,
  output logic [15:0]     sp_out,
  output logic [7:0]      acc_out,
  output logic [15:0]     bc_out,
  output logic [15:0]     de_out,
  output logic [15:0]     hl_out,
  output logic [4:0]      flags_out,
  output logic            irq_enabled
);
  logic [15:0] pc_r, pc_nxt, sp_r, sp_nxt;
  logic [7:0]  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [7:0]  e_r, e_nxt, h_r, h_nxt, l_r, l_nxt;
  logic [4:0]  f_r, f_nxt;
  logic        ie_r, ie_nxt;
  logic [7:0]  op_r, b1_r, b2_r, m1_r;
  logic [15:0] addr;
  logic [7:0]  rdata;
  logic [15:0] bc, de, hl, wd;
  logic        known;

  assign bc = {b_r, c_r};
  assign de = {d_r, e_r};
  assign hl = {h_r, l_r};
  assign wd = {b2_r, b1_r};

  always_comb begin
    case (cmd.addr_sel)
      cpu8_pkg::AS_PC:   addr = pc_r;
      cpu8_pkg::AS_PC1:  addr = pc_r + 16'd1;
      cpu8_pkg::AS_PC2:  addr = pc_r + 16'd2;
      cpu8_pkg::AS_HL:   addr = hl;
      cpu8_pkg::AS_DE:   addr = de;
      cpu8_pkg::AS_WORD: addr = wd;
      cpu8_pkg::AS_SP:   addr = sp_r;
      cpu8_pkg::AS_SP1:  addr = sp_r + 16'd1;
      default:           addr = pc_r;
    endcase
    if (cmd.use_load) begin
      addr = load_address;
    end
  end

  cpu8_ram #(.WIDTH(8), .DEPTH(cpu8_pkg::MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.mem_we),
    .addr  (addr[cpu8_pkg::MEM_AW-1:0]),
    .wdata (cmd.use_load ? load_byte : cmd.wdata),
    .rdata (rdata)
  );

  // Instruction execution. Operands b1/b2 and read byte m1 (low) are captured before
  // this step; the high byte of a pop is taken straight from rdata.
  always_comb begin
    logic [15:0] n1, n2, n3, pop;
    logic [16:0] dsum;
    logic [8:0]  asum;
    logic [7:0]  t;
    pc_nxt = pc_r; sp_nxt = sp_r; a_nxt = a_r;
    b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r; h_nxt = h_r; l_nxt = l_r;
    f_nxt = f_r; ie_nxt = ie_r; known = 1'b1;
    n1 = pc_r + 16'd1; n2 = pc_r + 16'd2; n3 = pc_r + 16'd3;
    pop = {rdata, m1_r};
    dsum = 17'd0; asum = 9'd0; t = 8'd0;
    pc_nxt = n1;
    case (op_r)
      cpu8_pkg::OP_NOP: ;
      cpu8_pkg::OP_LXIB: begin {b_nxt, c_nxt} = wd; pc_nxt = n3; end
      cpu8_pkg::OP_LXID: begin {d_nxt, e_nxt} = wd; pc_nxt = n3; end
      cpu8_pkg::OP_LXIH: begin {h_nxt, l_nxt} = wd; pc_nxt = n3; end
      cpu8_pkg::OP_LXIS: begin sp_nxt = wd; pc_nxt = n3; end
      cpu8_pkg::OP_DCRB, cpu8_pkg::OP_DCRC: begin
        t = ((op_r == cpu8_pkg::OP_DCRB) ? b_r : c_r) - 8'd1;
        f_nxt[0] = (t == 8'd0); f_nxt[1] = t[7]; f_nxt[2] = cpu8_pkg::even_par(t);
        if (op_r == cpu8_pkg::OP_DCRB) b_nxt = t; else c_nxt = t;
      end
      cpu8_pkg::OP_MVIB: begin b_nxt = b1_r; pc_nxt = n2; end
      cpu8_pkg::OP_MVIC: begin c_nxt = b1_r; pc_nxt = n2; end
      cpu8_pkg::OP_MVIH: begin h_nxt = b1_r; pc_nxt = n2; end
      cpu8_pkg::OP_MVIA: begin a_nxt = b1_r; pc_nxt = n2; end
      cpu8_pkg::OP_MVIM: pc_nxt = n2;
      cpu8_pkg::OP_DADB, cpu8_pkg::OP_DADD, cpu8_pkg::OP_DADH: begin
        case (op_r)
          cpu8_pkg::OP_DADB: dsum = {1'b0, hl} + {1'b0, bc};
          cpu8_pkg::OP_DADD: dsum = {1'b0, hl} + {1'b0, de};
          default:           dsum = {1'b0, hl} + {1'b0, hl};
        endcase
        {h_nxt, l_nxt} = dsum[15:0]; f_nxt[3] = dsum[16];
      end
      cpu8_pkg::OP_RRC: begin a_nxt = {a_r[0], a_r[7:1]}; f_nxt[3] = a_r[0]; end
      cpu8_pkg::OP_INXD: {d_nxt, e_nxt} = de + 16'd1;
      cpu8_pkg::OP_INXH: {h_nxt, l_nxt} = hl + 16'd1;
      cpu8_pkg::OP_LDAX: a_nxt = m1_r;
      cpu8_pkg::OP_STA: pc_nxt = n3;
      cpu8_pkg::OP_LDA: begin a_nxt = m1_r; pc_nxt = n3; end
      cpu8_pkg::OP_MOVDM: d_nxt = m1_r;
      cpu8_pkg::OP_MOVEM: e_nxt = m1_r;
      cpu8_pkg::OP_MOVHM: h_nxt = m1_r;
      cpu8_pkg::OP_MOVLA: l_nxt = a_r;
      cpu8_pkg::OP_MOVMA: ;
      cpu8_pkg::OP_MOVAD: a_nxt = d_r;
      cpu8_pkg::OP_MOVAE: a_nxt = e_r;
      cpu8_pkg::OP_MOVAH: a_nxt = h_r;
      cpu8_pkg::OP_MOVAM: a_nxt = m1_r;
      cpu8_pkg::OP_ANA, cpu8_pkg::OP_XRA, cpu8_pkg::OP_ANI: begin
        case (op_r)
          cpu8_pkg::OP_ANA: t = a_r;
          cpu8_pkg::OP_XRA: t = 8'd0;
          default: begin t = a_r & b1_r; pc_nxt = n2; end
        endcase
        a_nxt = t;
        f_nxt = {1'b0, 1'b0, cpu8_pkg::even_par(t), t[7], (t == 8'd0)};
      end
      cpu8_pkg::OP_ADI: begin
        asum = {1'b0, a_r} + {1'b0, b1_r}; t = asum[7:0];
        f_nxt[0] = (t == 8'd0); f_nxt[1] = t[7]; f_nxt[2] = cpu8_pkg::even_par(t);
        f_nxt[3] = asum[8]; a_nxt = t; pc_nxt = n2;
      end
      cpu8_pkg::OP_CPI: begin
        t = a_r - b1_r;
        f_nxt[0] = (t == 8'd0); f_nxt[1] = t[7]; f_nxt[2] = cpu8_pkg::even_par(t);
        f_nxt[3] = (a_r < b1_r); pc_nxt = n2;
      end
      cpu8_pkg::OP_JMP: pc_nxt = wd;
      cpu8_pkg::OP_JNZ: pc_nxt = f_r[0] ? n3 : wd;
      cpu8_pkg::OP_CALL: begin sp_nxt = sp_r - 16'd2; pc_nxt = wd; end
      cpu8_pkg::OP_RET: begin pc_nxt = pop; sp_nxt = sp_r + 16'd2; end
      cpu8_pkg::OP_POPB: begin {b_nxt, c_nxt} = pop; sp_nxt = sp_r + 16'd2; end
      cpu8_pkg::OP_POPD: begin {d_nxt, e_nxt} = pop; sp_nxt = sp_r + 16'd2; end
      cpu8_pkg::OP_POPH: begin {h_nxt, l_nxt} = pop; sp_nxt = sp_r + 16'd2; end
      cpu8_pkg::OP_POPP: begin
        a_nxt = pop[15:8]; f_nxt = pop[4:0]; sp_nxt = sp_r + 16'd2;
      end
      cpu8_pkg::OP_PSHB, cpu8_pkg::OP_PSHD, cpu8_pkg::OP_PSHH, cpu8_pkg::OP_PSHP:
        sp_nxt = sp_r - 16'd2;
      cpu8_pkg::OP_OUT: pc_nxt = n2;
      cpu8_pkg::OP_XCHG: begin {d_nxt, e_nxt} = hl; {h_nxt, l_nxt} = de; end
      cpu8_pkg::OP_EI: ie_nxt = 1'b1;
      default: known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 16'd0; sp_r <= 16'd0; a_r <= 8'd0; f_r <= 5'd0; ie_r <= 1'b0;
      b_r <= 8'd0; c_r <= 8'd0; d_r <= 8'd0; e_r <= 8'd0; h_r <= 8'd0; l_r <= 8'd0;
    end else if (cfg_we) begin
      pc_r <= cfg_data;
    end else if (cmd.exec) begin
      pc_r <= pc_nxt; sp_r <= sp_nxt; a_r <= a_nxt; f_r <= f_nxt; ie_r <= ie_nxt;
      b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt; h_r <= h_nxt;
      l_r <= l_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_op) op_r <= rdata;
    if (cmd.cap_b1) b1_r <= rdata;
    if (cmd.cap_b2) b2_r <= rdata;
    if (cmd.cap_m1) m1_r <= rdata;
    if (cmd.exec) begin
      opcode_done  <= op_r;
      opcode_known <= known;
    end else if (cmd.clr_op) begin
      opcode_done  <= 8'd0;
      opcode_known <= 1'b0;
    end
  end

  assign pc_out = pc_r; assign sp_out = sp_r; assign acc_out = a_r;
  assign bc_out = bc; assign de_out = de; assign hl_out = hl;
  assign flags_out = f_r; assign irq_enabled = ie_r;

  assign stat.op = op_r;
  assign word = wd; assign a_val = a_r; assign b1_val = b1_r;
  assign bc_val = bc; assign de_val = de; assign hl_val = hl;
  assign pc_val = pc_r; assign sp_val = sp_r; assign f_val = f_r;
endmodule

FILE: rtl/core/cpu8_ctrl.sv
// Controller state machine of the cpu8 core: sequences memory accesses per item.
module cpu8_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  output logic             out_valid,
  input  logic             out_stall,
  input  cpu8_pkg::stat_t  stat,
  input  logic [7:0]       a_val,
  input  logic [7:0]       b1_val,
  input  logic [15:0]      bc_val,
  input  logic [15:0]      de_val,
  input  logic [15:0]      hl_val,
  input  logic [15:0]      pc_val,
  input  logic [4:0]       f_val,
  output cpu8_pkg::cmd_t   cmd,
  output cpu8_pkg::state_t state,
  output logic             busy
);
  cpu8_pkg::state_t state_r, state_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       op;
  logic [15:0]      n3;

  assign op = stat.op;
  assign n3 = pc_val + 16'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpu8_pkg::ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Accepting requires the controller to be idle and the output register to be free or being drained.
  assign in_stall  = !(state_r == cpu8_pkg::ST_IDLE && (!ov_r || !out_stall));
  assign out_valid = ov_r;
  assign busy      = (state_r != cpu8_pkg::ST_IDLE);
  assign state     = state_r;

  always_comb begin
    logic is_pop, is_push, rd_hl;
    state_nxt = state_r;
    ov_nxt = ov_r && out_stall;
    cmd = '0;
    cmd.addr_sel = cpu8_pkg::AS_PC;
    is_pop  = (op == cpu8_pkg::OP_RET || op == cpu8_pkg::OP_POPB ||
               op == cpu8_pkg::OP_POPD || op == cpu8_pkg::OP_POPH ||
               op == cpu8_pkg::OP_POPP);
    is_push = (op == cpu8_pkg::OP_PSHB || op == cpu8_pkg::OP_PSHD ||
               op == cpu8_pkg::OP_PSHH || op == cpu8_pkg::OP_PSHP ||
               op == cpu8_pkg::OP_CALL);
    rd_hl   = (op == cpu8_pkg::OP_MOVDM || op == cpu8_pkg::OP_MOVEM ||
               op == cpu8_pkg::OP_MOVHM || op == cpu8_pkg::OP_MOVAM);
    case (state_r)
      cpu8_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (in_kind) begin
            state_nxt = cpu8_pkg::ST_FETCH;
          end else begin
            cmd.use_load = 1'b1;
            cmd.mem_we   = 1'b1;
            state_nxt    = cpu8_pkg::ST_LOAD;
          end
        end
      end
      cpu8_pkg::ST_LOAD: begin
        cmd.clr_op = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = cpu8_pkg::ST_IDLE;
      end
      cpu8_pkg::ST_FETCH: begin
        // Read data of this cycle's address appears next cycle.
        cmd.addr_sel = cpu8_pkg::AS_PC1;
        state_nxt = cpu8_pkg::ST_OPER1;
        cmd.cap_op = 1'b1;
      end
      cpu8_pkg::ST_OPER1: begin
        cmd.cap_b1 = 1'b1;
        cmd.addr_sel = cpu8_pkg::AS_PC2;
        state_nxt = cpu8_pkg::ST_OPER2;
      end
      cpu8_pkg::ST_OPER2: begin
        cmd.cap_b2 = 1'b1;
        state_nxt = cpu8_pkg::ST_RD1;
      end
      cpu8_pkg::ST_RD1: begin
        // Issue the data read or data write, by opcode; a push write here is dropped by cpu8_stk.
        state_nxt = cpu8_pkg::ST_RD2;
        if (is_pop) begin
          cmd.addr_sel = cpu8_pkg::AS_SP;
        end else if (op == cpu8_pkg::OP_LDAX) begin
          cmd.addr_sel = cpu8_pkg::AS_DE;
        end else if (op == cpu8_pkg::OP_LDA) begin
          cmd.addr_sel = cpu8_pkg::AS_WORD;
        end else if (rd_hl) begin
          cmd.addr_sel = cpu8_pkg::AS_HL;
        end else if (op == cpu8_pkg::OP_MVIM || op == cpu8_pkg::OP_MOVMA) begin
          cmd.addr_sel = cpu8_pkg::AS_HL;
          cmd.mem_we = 1'b1;
          cmd.wdata = (op == cpu8_pkg::OP_MVIM) ? b1_val : a_val;
        end else if (op == cpu8_pkg::OP_STA) begin
          cmd.addr_sel = cpu8_pkg::AS_WORD;
          cmd.mem_we = 1'b1;
          cmd.wdata = a_val;
        end else if (is_push) begin
          cmd.addr_sel = cpu8_pkg::AS_SP;
          cmd.mem_we = 1'b1;
          cmd.wdata = 8'd0;
        end
      end
      cpu8_pkg::ST_RD2: begin
        // The data byte, or the low byte of a pop, is held for the execute step.
        state_nxt = cpu8_pkg::ST_EXEC;
        cmd.cap_m1 = 1'b1;
        if (is_pop) begin
          cmd.addr_sel = cpu8_pkg::AS_SP1;
        end
      end
      cpu8_pkg::ST_EXEC: begin
        if (is_push) begin
          // Stack writes go below SP before it moves: high at SP-1, low at SP-2.
          state_nxt = cpu8_pkg::ST_WR2;
        end else begin
          cmd.exec = 1'b1;
          state_nxt = cpu8_pkg::ST_DONE;
        end
      end
      cpu8_pkg::ST_WR2: begin
        cmd.exec = 1'b1;
        state_nxt = cpu8_pkg::ST_DONE;
      end
      cpu8_pkg::ST_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = cpu8_pkg::ST_IDLE;
      end
      default: state_nxt = cpu8_pkg::ST_IDLE;
    endcase
    if (state_r == cpu8_pkg::ST_EXEC && is_push) begin
      cmd.mem_we = 1'b1;
      cmd.addr_sel = cpu8_pkg::AS_SP;
      case (op)
        cpu8_pkg::OP_PSHB: cmd.wdata = bc_val[15:8];
        cpu8_pkg::OP_PSHD: cmd.wdata = de_val[15:8];
        cpu8_pkg::OP_PSHH: cmd.wdata = hl_val[15:8];
        cpu8_pkg::OP_PSHP: cmd.wdata = a_val;
        default:           cmd.wdata = n3[15:8];
      endcase
    end
    if (state_r == cpu8_pkg::ST_WR2) begin
      cmd.mem_we = 1'b1;
      cmd.addr_sel = cpu8_pkg::AS_SP;
      case (op)
        cpu8_pkg::OP_PSHB: cmd.wdata = bc_val[7:0];
        cpu8_pkg::OP_PSHD: cmd.wdata = de_val[7:0];
        cpu8_pkg::OP_PSHH: cmd.wdata = hl_val[7:0];
        cpu8_pkg::OP_PSHP: cmd.wdata = {3'd0, f_val};
        default:           cmd.wdata = n3[7:0];
      endcase
    end
  end
endmodule

FILE: rtl/core/cpu8_stk.sv
// Stack address adapter: flags the two push writes of the cpu8 core for an SP offset.
module cpu8_stk (
  input  cpu8_pkg::cmd_t   cmd_in,
  input  cpu8_pkg::state_t state,
  output cpu8_pkg::cmd_t   cmd_out,
  output logic             sp_dec1,
  output logic             sp_dec2
);
  // Push writes land at SP-1 (high) and SP-2 (low) via flags to the top level; a push write in RD1 is dropped.
  always_comb begin
    cmd_out = cmd_in;
    sp_dec1 = cmd_in.mem_we && state == cpu8_pkg::ST_EXEC &&
              cmd_in.addr_sel == cpu8_pkg::AS_SP;
    sp_dec2 = cmd_in.mem_we && state == cpu8_pkg::ST_WR2 &&
              cmd_in.addr_sel == cpu8_pkg::AS_SP;
    if (cmd_in.mem_we && state == cpu8_pkg::ST_RD1 &&
        cmd_in.addr_sel == cpu8_pkg::AS_SP) begin
      cmd_out.mem_we = 1'b0;
    end
  end
endmodule

FILE: rtl/core/cpu8_instruction_execute.sv
// Top level of the cpu8 instruction execute core.
// An 8-bit core executing a subset of the classic 8080 instruction set out of a
// 64 KiB single-port byte memory. A load item (kind 0) writes one byte and its
// result is set valid from the LOAD state; a step item (kind 1) steps through the
// states FETCH, OPER1, OPER2, RD1, RD2, EXEC, WR2 (pushes and CALL only) and DONE,
// as the single memory port serves the opcode fetch, two operand reads, the data
// or stack reads and the stack writes in turn. One item is in work at a time; its
// result sits in an output register, and the next item is taken once that register
// is free or is drained in the same cycle. Writing start_pc also loads the program
// counter. Memory needs no clearing after reset.
module cpu8_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_opcode_done,
  output logic        out_opcode_known,
  output logic [15:0] out_pc_out,
  output logic [15:0] out_sp_out,
  output logic [7:0]  out_acc_out,
  output logic [15:0] out_bc_out,
  output logic [15:0] out_de_out,
  output logic [15:0] out_hl_out,
  output logic [4:0]  out_flags_out,
  output logic        out_irq_enabled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_start_pc
);
  cpu8_pkg::cmd_t   cmd, cmd_dp, cmd_mem;
  cpu8_pkg::stat_t  stat;
  cpu8_pkg::state_t ctrl_state;
  logic [15:0] word, bc_v, de_v, hl_v, pc_v, sp_v;
  logic [7:0]  a_v, b1_v;
  logic [4:0]  f_v;
  logic        busy, dec1, dec2;
  logic [15:0] load_addr;

  assign cfg_ready = 1'b1;

  cpu8_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .out_valid, .out_stall,
    .stat, .a_val(a_v), .b1_val(b1_v), .bc_val(bc_v), .de_val(de_v),
    .hl_val(hl_v), .pc_val(pc_v), .f_val(f_v), .cmd, .state(ctrl_state), .busy
  );

  cpu8_stk u_stk (
    .cmd_in(cmd), .state(ctrl_state), .cmd_out(cmd_dp),
    .sp_dec1(dec1), .sp_dec2(dec2)
  );

  // Push writes reuse the load address path with an SP offset.
  always_comb begin
    load_addr = in_load_address;
    if (dec1) load_addr = sp_v - 16'd1;
    if (dec2) load_addr = sp_v - 16'd2;
    cmd_mem = cmd_dp;
    cmd_mem.use_load = cmd_dp.use_load || dec1 || dec2;
  end

  cpu8_dp u_dp (
    .clk, .rst_n,
    .cmd(cmd_mem),
    .load_address(load_addr),
    .load_byte((dec1 || dec2) ? cmd_dp.wdata : in_load_byte),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_start_pc),
    .stat, .word, .a_val(a_v), .b1_val(b1_v), .bc_val(bc_v), .de_val(de_v),
    .hl_val(hl_v), .pc_val(pc_v), .sp_val(sp_v), .f_val(f_v),
    .opcode_done(out_opcode_done), .opcode_known(out_opcode_known),
    .pc_out(out_pc_out), .sp_out(out_sp_out), .acc_out(out_acc_out),
    .bc_out(out_bc_out), .de_out(out_de_out), .hl_out(out_hl_out),
    .flags_out(out_flags_out), .irq_enabled(out_irq_enabled)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall) else $error("item accepted while busy");
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec) else $error("exec repeated");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result lost");
  a_word_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && stat.op == cpu8_pkg::OP_JMP) |=> out_pc_out == $past(word))
    else $error("jump target wrong");
endmodule

FILE: verif/cpu8_instruction_execute_test.sv
// Self-checking testbench for the cpu8 instruction execute core.
module cpu8_instruction_execute_test;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int FZ = 0, FS = 1, FP = 2, FCY = 3, FAC = 4;
  localparam bit KIND_LOAD = 1'b0, KIND_STEP = 1'b1;

  localparam logic [7:0] KNOWN_OPS [50] = '{
    cpu8_pkg::OP_NOP, cpu8_pkg::OP_LXIB, cpu8_pkg::OP_LXID, cpu8_pkg::OP_LXIH,
    cpu8_pkg::OP_LXIS, cpu8_pkg::OP_DCRB, cpu8_pkg::OP_DCRC, cpu8_pkg::OP_MVIB,
    cpu8_pkg::OP_MVIC, cpu8_pkg::OP_MVIH, cpu8_pkg::OP_MVIA, cpu8_pkg::OP_MVIM,
    cpu8_pkg::OP_DADB, cpu8_pkg::OP_DADD, cpu8_pkg::OP_DADH, cpu8_pkg::OP_RRC,
    cpu8_pkg::OP_INXD, cpu8_pkg::OP_INXH, cpu8_pkg::OP_LDAX, cpu8_pkg::OP_STA,
    cpu8_pkg::OP_LDA, cpu8_pkg::OP_MOVDM, cpu8_pkg::OP_MOVEM, cpu8_pkg::OP_MOVHM,
    cpu8_pkg::OP_MOVLA, cpu8_pkg::OP_MOVMA, cpu8_pkg::OP_MOVAD, cpu8_pkg::OP_MOVAE,
    cpu8_pkg::OP_MOVAH, cpu8_pkg::OP_MOVAM, cpu8_pkg::OP_ANA, cpu8_pkg::OP_XRA,
    cpu8_pkg::OP_ANI, cpu8_pkg::OP_ADI, cpu8_pkg::OP_CPI, cpu8_pkg::OP_JMP,
    cpu8_pkg::OP_JNZ, cpu8_pkg::OP_CALL, cpu8_pkg::OP_RET, cpu8_pkg::OP_POPB,
    cpu8_pkg::OP_POPD, cpu8_pkg::OP_POPH, cpu8_pkg::OP_PSHB, cpu8_pkg::OP_PSHD,
    cpu8_pkg::OP_PSHH, cpu8_pkg::OP_PSHP, cpu8_pkg::OP_POPP, cpu8_pkg::OP_OUT,
    cpu8_pkg::OP_XCHG, cpu8_pkg::OP_EI};

  typedef struct packed {
    logic [7:0]  op;
    logic        known;
    logic [15:0] pc;
    logic [15:0] sp;
    logic [7:0]  acc;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [4:0]  flg;
    logic        ie;
  } cpu_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [15:0] in_load_address = '0;
  logic [7:0]  in_load_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_opcode_done;
  logic        out_opcode_known;
  logic [15:0] out_pc_out, out_sp_out, out_bc_out, out_de_out, out_hl_out;
  logic [7:0]  out_acc_out;
  logic [4:0]  out_flags_out;
  logic        out_irq_enabled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_start_pc = '0;

  cpu8_instruction_execute uut (.*);

  // Shadow machine state.
  logic [7:0]  mem [0:65535];
  bit          mem_set [0:65535];
  logic [15:0] pc, sp;
  logic [7:0]  acc, rb, rc, rd, re, rh, rl;
  logic [4:0]  flg;
  logic        ie;

  cpu_view_t   expected_states[$];
  int          idle_pct = 0, stall_pct = 0;
  int          mismatches = 0, results_seen = 0, items_sent = 0, steps_sent = 0;
  int          unknown_steps = 0, quiet_cycles = 0;
  bit          in_take, out_take;
  cpu_view_t   seen;

  initial forever #10 clk = ~clk;

  task automatic set_zsp(input logic [7:0] v);
    flg[FZ] = (v == 8'h00);
    flg[FS] = v[7];
    flg[FP] = ~^v;
  endtask

  task automatic push_word(input logic [7:0] hi, input logic [7:0] lo);
    mem[sp - 16'd1] = hi;
    mem_set[sp - 16'd1] = 1'b1;
    mem[sp - 16'd2] = lo;
    mem_set[sp - 16'd2] = 1'b1;
    sp = sp - 16'd2;
  endtask

  task automatic pop_word(output logic [15:0] w);
    w = {mem[sp + 16'd1], mem[sp]};
    sp = sp + 16'd2;
  endtask

  task automatic add_hl(input logic [15:0] v);
    logic [16:0] r;
    r = {1'b0, rh, rl} + {1'b0, v};
    {rh, rl} = r[15:0];
    flg[FCY] = r[16];
  endtask

  // Advances the shadow machine by one instruction; returns whether it was known.
  task automatic run_instruction(input logic [7:0] op, output logic known);
    logic [7:0]  b1, b2, t;
    logic [15:0] word, w, nx3;
    logic [8:0]  sum;
    b1 = mem[pc + 16'd1];
    b2 = mem[pc + 16'd2];
    word = {b2, b1};
    nx3 = pc + 16'd3;
    known = 1'b1;
    pc = pc + 16'd1;
    case (op)
      cpu8_pkg::OP_NOP: ;
      cpu8_pkg::OP_LXIB: begin {rb, rc} = word; pc = nx3; end
      cpu8_pkg::OP_LXID: begin {rd, re} = word; pc = nx3; end
      cpu8_pkg::OP_LXIH: begin {rh, rl} = word; pc = nx3; end
      cpu8_pkg::OP_LXIS: begin sp = word; pc = nx3; end
      cpu8_pkg::OP_DCRB: begin rb = rb - 8'd1; set_zsp(rb); end
      cpu8_pkg::OP_DCRC: begin rc = rc - 8'd1; set_zsp(rc); end
      cpu8_pkg::OP_MVIB: begin rb = b1; pc = pc + 16'd1; end
      cpu8_pkg::OP_MVIC: begin rc = b1; pc = pc + 16'd1; end
      cpu8_pkg::OP_MVIH: begin rh = b1; pc = pc + 16'd1; end
      cpu8_pkg::OP_MVIA: begin acc = b1; pc = pc + 16'd1; end
      cpu8_pkg::OP_MVIM: begin
        mem[{rh, rl}] = b1;
        mem_set[{rh, rl}] = 1'b1;
        pc = pc + 16'd1;
      end
      cpu8_pkg::OP_DADB: add_hl({rb, rc});
      cpu8_pkg::OP_DADD: add_hl({rd, re});
      cpu8_pkg::OP_DADH: add_hl({rh, rl});
      cpu8_pkg::OP_RRC: begin flg[FCY] = acc[0]; acc = {acc[0], acc[7:1]}; end
      cpu8_pkg::OP_INXD: {rd, re} = {rd, re} + 16'd1;
      cpu8_pkg::OP_INXH: {rh, rl} = {rh, rl} + 16'd1;
      cpu8_pkg::OP_LDAX: acc = mem[{rd, re}];
      cpu8_pkg::OP_STA: begin mem[word] = acc; mem_set[word] = 1'b1; pc = nx3; end
      cpu8_pkg::OP_LDA: begin acc = mem[word]; pc = nx3; end
      cpu8_pkg::OP_MOVDM: rd = mem[{rh, rl}];
      cpu8_pkg::OP_MOVEM: re = mem[{rh, rl}];
      cpu8_pkg::OP_MOVHM: rh = mem[{rh, rl}];
      cpu8_pkg::OP_MOVLA: rl = acc;
      cpu8_pkg::OP_MOVMA: begin mem[{rh, rl}] = acc; mem_set[{rh, rl}] = 1'b1; end
      cpu8_pkg::OP_MOVAD: acc = rd;
      cpu8_pkg::OP_MOVAE: acc = re;
      cpu8_pkg::OP_MOVAH: acc = rh;
      cpu8_pkg::OP_MOVAM: acc = mem[{rh, rl}];
      cpu8_pkg::OP_ANA, cpu8_pkg::OP_XRA, cpu8_pkg::OP_ANI: begin
        if (op == cpu8_pkg::OP_XRA) acc = 8'h00;
        if (op == cpu8_pkg::OP_ANI) begin
          acc = acc & b1;
          pc = pc + 16'd1;
        end
        set_zsp(acc);
        flg[FCY] = 1'b0;
        flg[FAC] = 1'b0;
      end
      cpu8_pkg::OP_ADI: begin
        sum = {1'b0, acc} + {1'b0, b1};
        set_zsp(sum[7:0]);
        flg[FCY] = sum[8];
        acc = sum[7:0];
        pc = pc + 16'd1;
      end
      cpu8_pkg::OP_CPI: begin
        t = acc - b1;
        set_zsp(t);
        flg[FCY] = (acc < b1);
        pc = pc + 16'd1;
      end
      cpu8_pkg::OP_JMP: pc = word;
      cpu8_pkg::OP_JNZ: pc = flg[FZ] ? nx3 : word;
      cpu8_pkg::OP_CALL: begin push_word(nx3[15:8], nx3[7:0]); pc = word; end
      cpu8_pkg::OP_RET: pop_word(pc);
      cpu8_pkg::OP_POPB: begin pop_word(w); {rb, rc} = w; end
      cpu8_pkg::OP_POPD: begin pop_word(w); {rd, re} = w; end
      cpu8_pkg::OP_POPH: begin pop_word(w); {rh, rl} = w; end
      cpu8_pkg::OP_PSHB: push_word(rb, rc);
      cpu8_pkg::OP_PSHD: push_word(rd, re);
      cpu8_pkg::OP_PSHH: push_word(rh, rl);
      cpu8_pkg::OP_PSHP: push_word(acc, {3'b000, flg});
      cpu8_pkg::OP_POPP: begin pop_word(w); acc = w[15:8]; flg = w[4:0]; end
      cpu8_pkg::OP_OUT: pc = pc + 16'd1;
      cpu8_pkg::OP_XCHG: begin w = {rd, re}; {rd, re} = {rh, rl}; {rh, rl} = w; end
      cpu8_pkg::OP_EI: ie = 1'b1;
      default: known = 1'b0;
    endcase
  endtask

  task automatic clear_shadow(input logic [15:0] start);
    pc = start;
    sp = '0;
    acc = '0;
    {rb, rc, rd, re, rh, rl} = '0;
    flg = '0;
    ie = 1'b0;
    for (int i = 0; i < 65536; i++) mem_set[i] = 1'b0;
  endtask

  // Drives one item and waits until it is taken; the expected state is queued then.
  task automatic send_item(input bit kind, input logic [15:0] addr, input logic [7:0] data);
    cpu_view_t v;
    logic known;
    bit ok;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_load_address <= addr;
    in_load_byte <= data;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    v.op = 8'h00;
    known = 1'b0;
    if (kind == KIND_LOAD) begin
      mem[addr] = data;
      mem_set[addr] = 1'b1;
    end else begin
      v.op = mem[pc];
      run_instruction(v.op, known);
      steps_sent++;
      if (!known) unknown_steps++;
    end
    v.known = known;
    v.pc = pc;
    v.sp = sp;
    v.acc = acc;
    v.bc = {rb, rc};
    v.de = {rd, re};
    v.hl = {rh, rl};
    v.flg = flg;
    v.ie = ie;
    expected_states.push_back(v);
    items_sent++;
  endtask

  task automatic release_inputs();
    in_valid <= 1'b0;
  endtask

  task automatic load_if_missing(input logic [15:0] a);
    if (!mem_set[a]) send_item(KIND_LOAD, a, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  // Places an opcode and operands at the program counter when asked to, makes sure every
  // byte the instruction reads has been written, then executes it.
  task automatic place_and_step(input bit new_op, input logic [7:0] op, input bit new_args);
    logic [7:0] code;
    if (new_op) send_item(KIND_LOAD, pc, op);
    else load_if_missing(pc);
    if (new_args) begin
      send_item(KIND_LOAD, pc + 16'd1, pick_byte());
      send_item(KIND_LOAD, pc + 16'd2, pick_byte());
    end
    load_if_missing(pc + 16'd1);
    load_if_missing(pc + 16'd2);
    code = mem[pc];
    case (code)
      cpu8_pkg::OP_MOVDM, cpu8_pkg::OP_MOVEM, cpu8_pkg::OP_MOVHM, cpu8_pkg::OP_MOVAM:
        load_if_missing({rh, rl});
      cpu8_pkg::OP_LDAX: load_if_missing({rd, re});
      cpu8_pkg::OP_LDA: load_if_missing({mem[pc + 16'd2], mem[pc + 16'd1]});
      cpu8_pkg::OP_RET, cpu8_pkg::OP_POPB, cpu8_pkg::OP_POPD, cpu8_pkg::OP_POPH,
      cpu8_pkg::OP_POPP: begin
        load_if_missing(sp);
        load_if_missing(sp + 16'd1);
      end
      default: ;
    endcase
    send_item(KIND_STEP, '0, '0);
  endtask

  task automatic wait_for_results();
    while (expected_states.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_start_pc(input logic [15:0] value);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_start_pc <= value;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    pc = value;
  endtask

  // Every implemented opcode once, operands often extreme, then an unimplemented opcode and two loads.
  task automatic test_every_opcode();
    foreach (KNOWN_OPS[i]) place_and_step(1'b1, KNOWN_OPS[i], 1'b1);
    place_and_step(1'b1, 8'h76, 1'b1);
    send_item(KIND_LOAD, 16'hffff, 8'hff);
    send_item(KIND_LOAD, 16'h0000, 8'h00);
  endtask

  // Mostly well-formed instructions with random content; the rest are stray loads, random
  // opcodes and runs of whatever code is already in memory.
  task automatic test_random_program(input int n, input int idle, input int stall);
    int start;
    idle_pct = idle;
    stall_pct = stall;
    start = items_sent;
    while (items_sent - start < n) begin
      case ($urandom_range(9))
        0: send_item(KIND_LOAD, 16'($urandom), 8'($urandom));
        1: place_and_step(1'b1, 8'($urandom), 1'b1);
        2: place_and_step(1'b0, 8'h00, 1'b0);
        default: place_and_step(1'b1, KNOWN_OPS[$urandom_range(49)], 1'b1);
      endcase
    end
  endtask

  // The sender holds off until every expected result has come before each item.
  task automatic test_drained_sends(input int n);
    idle_pct = 0;
    stall_pct = 50;
    repeat (n) begin
      release_inputs();
      while (expected_states.size() != 0) @(posedge clk);
      place_and_step(1'b1, KNOWN_OPS[$urandom_range(49)], 1'b1);
    end
  endtask

  task automatic test_start_pc(input logic [15:0] value, input int n);
    release_inputs();
    wait_for_results();
    write_start_pc(value);
    test_random_program(n, 0, 0);
  endtask

  initial begin
    clear_shadow(16'h0000);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_start_pc(16'hfffe);
    test_every_opcode();
    test_random_program(280, 0, 0);
    test_random_program(280, 68, 0);
    test_random_program(280, 0, 68);
    test_random_program(280, 21, 21);
    test_drained_sends(20);
    test_start_pc(16'hffff, 100);
    test_start_pc(16'h0000, 100);
    test_start_pc(16'($urandom), 50);
    release_inputs();
    wait_for_results();
    $display("Ran %0d items (%0d instructions, %0d unimplemented opcodes), %0d results.",
             items_sent, steps_sent, unknown_steps, results_seen);
    $display("Covered every opcode, address wrap, several start addresses and stall mixes.");
    if (mismatches == 0) begin
      $display("cpu8_instruction_execute: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("cpu8_instruction_execute: mismatch");
    end
    $finish;
  end

  // Handshakes are sampled at the falling edge, when inputs and outputs are settled.
  always @(negedge clk) begin
    in_take = in_valid && !in_stall;
    out_take = out_valid && !out_stall;
    seen = '{out_opcode_done, out_opcode_known, out_pc_out, out_sp_out, out_acc_out,
             out_bc_out, out_de_out, out_hl_out, out_flags_out, out_irq_enabled};
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_take) begin
        results_seen++;
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result with no item outstanding: %p", seen);
        end else if (seen !== expected_states[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Wrong result\n  expected %p\n  actual   %p", expected_states[0], seen);
        end
        if (expected_states.size() != 0) void'(expected_states.pop_front());
      end
      if (in_take || out_take || cfg_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timed out with %0d results outstanding", expected_states.size());
        $display("cpu8_instruction_execute: mismatch");
        $finish;
      end
    end
  end

endmodule
